// File: rtl/sckt_pkg.sv
// package for the scan code to hid key state tracker
// holds event kinds, report kinds, register indexes, queue word type and the scan code roms
// no dependencies
package sckt_pkg;

  localparam int unsigned ScanW  = 8;
  localparam int unsigned UsageW = 8;

  typedef enum logic [2:0] {
    KIND_KEY     = 3'd0,
    KIND_TICK    = 3'd1,
    KIND_KEEP    = 3'd2,
    KIND_ENABLE  = 3'd3,
    KIND_DISABLE = 3'd4
  } in_kind_e;

  typedef enum logic [1:0] {
    RPT_CHANGE  = 2'd0,
    RPT_KEEP    = 2'd1,
    RPT_RELEASE = 2'd2,
    RPT_FULL    = 2'd3
  } rpt_kind_e;

  typedef enum logic [1:0] {
    OP_KEY     = 2'd0,
    OP_KEEP    = 2'd1,
    OP_DISABLE = 2'd2,
    OP_TICK    = 2'd3
  } op_e;

  // config register indexes
  typedef enum logic [2:0] {
    REG_MASK0  = 3'd0,
    REG_MASK1  = 3'd1,
    REG_MASK2  = 3'd2,
    REG_MASK3  = 3'd3,
    REG_FILTER = 3'd4,
    REG_WINDOW = 3'd5
  } reg_idx_e;

  localparam logic [UsageW-1:0] UsageEnd = 8'h4D;

  // classified word passed from front to back
  typedef struct packed {
    op_e               op;
    logic [UsageW-1:0] usage;
    logic              press;
  } cmd_t;

  function automatic logic [UsageW-1:0] plain_rom(input logic [ScanW-1:0] sc);
    logic [UsageW-1:0] u;
    u = '0;
    case (sc)
      8'h01: u = 8'h29; 8'h3B: u = 8'h3A; 8'h3C: u = 8'h3B; 8'h3D: u = 8'h3C;
      8'h3E: u = 8'h3D; 8'h3F: u = 8'h3E; 8'h40: u = 8'h3F; 8'h41: u = 8'h40;
      8'h42: u = 8'h41; 8'h43: u = 8'h42; 8'h44: u = 8'h43; 8'h57: u = 8'h44;
      8'h58: u = 8'h45; 8'h29: u = 8'h35; 8'h02: u = 8'h1E; 8'h03: u = 8'h1F;
      8'h04: u = 8'h20; 8'h05: u = 8'h21; 8'h06: u = 8'h22; 8'h07: u = 8'h23;
      8'h08: u = 8'h24; 8'h09: u = 8'h25; 8'h0A: u = 8'h26; 8'h0B: u = 8'h27;
      8'h0C: u = 8'h2D; 8'h0D: u = 8'h2E; 8'h0E: u = 8'h2A; 8'h0F: u = 8'h2B;
      8'h10: u = 8'h14; 8'h11: u = 8'h1A; 8'h12: u = 8'h08; 8'h13: u = 8'h15;
      8'h14: u = 8'h17; 8'h15: u = 8'h1C; 8'h16: u = 8'h18; 8'h17: u = 8'h0C;
      8'h18: u = 8'h12; 8'h19: u = 8'h13; 8'h1A: u = 8'h2F; 8'h1B: u = 8'h30;
      8'h2B: u = 8'h31; 8'h3A: u = 8'h39; 8'h1E: u = 8'h04; 8'h1F: u = 8'h16;
      8'h20: u = 8'h07; 8'h21: u = 8'h09; 8'h22: u = 8'h0A; 8'h23: u = 8'h0B;
      8'h24: u = 8'h0D; 8'h25: u = 8'h0E; 8'h26: u = 8'h0F; 8'h27: u = 8'h33;
      8'h28: u = 8'h34; 8'h1C: u = 8'h28; 8'h2A: u = 8'hE1; 8'h2C: u = 8'h1D;
      8'h2D: u = 8'h1B; 8'h2E: u = 8'h06; 8'h2F: u = 8'h19; 8'h30: u = 8'h05;
      8'h31: u = 8'h11; 8'h32: u = 8'h10; 8'h33: u = 8'h36; 8'h34: u = 8'h37;
      8'h35: u = 8'h38; 8'h36: u = 8'hE5; 8'h1D: u = 8'hE0; 8'h38: u = 8'hE2;
      8'h39: u = 8'h2C; 8'h46: u = 8'h47; 8'h45: u = 8'h53; 8'h37: u = 8'h55;
      8'h4A: u = 8'h56; 8'h4E: u = 8'h57; 8'h4F: u = 8'h59; 8'h50: u = 8'h5A;
      8'h51: u = 8'h5B; 8'h4B: u = 8'h5C; 8'h4C: u = 8'h5D; 8'h4D: u = 8'h5E;
      8'h47: u = 8'h5F; 8'h48: u = 8'h60; 8'h49: u = 8'h61; 8'h52: u = 8'h62;
      8'h53: u = 8'h63;
      default: u = '0;
    endcase
    return u;
  endfunction

  function automatic logic [UsageW-1:0] ext_rom(input logic [ScanW-1:0] sc);
    logic [UsageW-1:0] u;
    u = '0;
    case (sc)
      8'h1D: u = 8'hE4; 8'h38: u = 8'hE6; 8'h5B: u = 8'hE3; 8'h5C: u = 8'hE7;
      8'h5D: u = 8'h65; 8'h52: u = 8'h49; 8'h47: u = 8'h4A; 8'h49: u = 8'h4B;
      8'h53: u = 8'h4C; 8'h4F: u = 8'h4D; 8'h51: u = 8'h4E; 8'h48: u = 8'h52;
      8'h4B: u = 8'h50; 8'h50: u = 8'h51; 8'h4D: u = 8'h4F; 8'h1C: u = 8'h58;
      8'h35: u = 8'h54; 8'h37: u = 8'h46;
      default: u = '0;
    endcase
    return u;
  endfunction

endpackage

// File: rtl/sckt_front.sv
// front end: accepts input words, maps scan codes, applies the enable and filter
// depends on sckt_pkg
module sckt_front
  import sckt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          kind_i,
  input  logic [ScanW-1:0]    scan_code_i,
  input  logic                extended_i,
  input  logic                key_break_i,
  input  logic                vkey_invalid_i,
  input  logic [255:0]        allowed_i,
  input  logic                filter_en_i,
  output logic                push_o,
  output cmd_t                cmd_o,
  input  logic                full_i
);

  logic              enabled_q, enabled_d;
  logic [UsageW-1:0] usage;
  logic              acc;

  assign in_ready_o = !full_i;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    usage    = extended_i ? ext_rom(scan_code_i) : plain_rom(scan_code_i);
    enabled_d = enabled_q;
    push_o   = 1'b0;
    cmd_o.op    = OP_KEY;
    cmd_o.usage = usage;
    cmd_o.press = !key_break_i;
    if (acc) begin
      case (kind_i)
        KIND_KEY: begin
          if (enabled_q && !vkey_invalid_i && scan_code_i != '0 && usage != '0) begin
            if (usage == UsageEnd) begin
              if (!key_break_i) begin
                enabled_d = 1'b0;
                push_o    = 1'b1;
                cmd_o.op  = OP_DISABLE;
              end
            end else if (!filter_en_i || allowed_i[usage]) begin
              push_o = 1'b1;
            end
          end
        end
        KIND_TICK: begin
          push_o   = 1'b1;
          cmd_o.op = OP_TICK;
        end
        KIND_KEEP: begin
          push_o   = enabled_q;
          cmd_o.op = OP_KEEP;
        end
        KIND_ENABLE:  enabled_d = 1'b1;
        KIND_DISABLE: begin
          enabled_d = 1'b0;
          push_o    = 1'b1;
          cmd_o.op  = OP_DISABLE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
    end else begin
      enabled_q <= enabled_d;
    end
  end

endmodule

// File: rtl/sckt_fifo.sv
// short queue of classified words between front and back
// depends on sckt_pkg
module sckt_fifo
  import sckt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  cmd_t       mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;

  assign full_o  = cnt_q == 3'd4;
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 2'd1;
      if (pop_i)  rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + 3'(push_i) - 3'(pop_i);
    end
  end

endmodule

// File: rtl/sckt_back.sv
// back end: held list, debounce time memory and result sequencing
// depends on sckt_pkg
module sckt_back
  import sckt_pkg::*;
#(
  parameter int unsigned MaxHeld  = 16,
  parameter int unsigned TimeBits = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  cmd_t              cmd_i,
  output logic              pop_o,
  input  logic [7:0]        window_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [UsageW-1:0] usage_o,
  output logic              key_down_o,
  output logic [1:0]        report_kind_o,
  output logic              last_o
);

  localparam int unsigned IdxW = $clog2(MaxHeld);
  localparam int unsigned CntW = $clog2(MaxHeld + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOOK, ST_SCAN, ST_DECIDE, ST_SHIFT, ST_WALK, ST_CLEAR
  } state_e;

  state_e            state_q;
  logic [UsageW-1:0] held_q [MaxHeld];
  logic [CntW-1:0]   cnt_q;
  logic [IdxW-1:0]   idx_q;
  logic [CntW-1:0]   pos_q;
  logic              found_q;
  logic [255:0]      seen_q;
  logic [TimeBits-1:0] tmem [256];
  logic [TimeBits-1:0] ctime_q;
  logic [TimeBits-1:0] now_q;
  cmd_t              cur_q;
  logic              walk_rel_q;
  logic [TimeBits-1:0] elapsed;
  logic              ovld_q;

  assign elapsed       = now_q - ctime_q;
  assign out_valid_o   = ovld_q;
  assign pop_o         = (state_q == ST_IDLE) && valid_i && !ovld_q;

  always_ff @(posedge clk_i) begin
    ctime_q <= tmem[cur_q.usage];
    if (state_q == ST_DECIDE && !ovld_q && found_q != cur_q.press
        && !(seen_q[cur_q.usage] && elapsed < TimeBits'(window_i))
        && !(cur_q.press && cnt_q >= CntW'(MaxHeld))) begin
      tmem[cur_q.usage] <= now_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      idx_q      <= '0;
      pos_q      <= '0;
      found_q    <= 1'b0;
      seen_q     <= '0;
      now_q      <= '0;
      cur_q      <= '{op: OP_KEY, usage: '0, press: 1'b0};
      walk_rel_q <= 1'b0;
      ovld_q     <= 1'b0;
      usage_o    <= '0;
      key_down_o <= 1'b0;
      report_kind_o <= RPT_CHANGE;
      last_o     <= 1'b0;
    end else begin
      if (ovld_q && out_ready_i) ovld_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            cur_q <= cmd_i;
            idx_q <= '0;
            unique case (cmd_i.op)
              OP_TICK: now_q <= now_q + 1'b1;
              OP_KEY: begin
                found_q <= 1'b0;
                pos_q   <= cnt_q;
                state_q <= (cnt_q == '0) ? ST_LOOK : ST_SCAN;
              end
              OP_KEEP: if (cnt_q != '0) begin
                walk_rel_q <= 1'b0;
                state_q    <= ST_WALK;
              end
              OP_DISABLE: begin
                seen_q <= '0;
                if (cnt_q != '0) begin
                  walk_rel_q <= 1'b1;
                  state_q    <= ST_WALK;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          // one held entry compared per cycle
          if (!found_q && held_q[idx_q] == cur_q.usage) begin
            found_q <= 1'b1;
            pos_q   <= CntW'(idx_q);
          end
          if (CntW'(idx_q) + 1'b1 >= cnt_q) state_q <= ST_LOOK;
          else idx_q <= idx_q + 1'b1;
        end
        ST_LOOK: state_q <= ST_DECIDE;
        ST_DECIDE: begin
          if (!ovld_q) begin
            state_q <= ST_IDLE;
            if (found_q != cur_q.press) begin
              if (!(seen_q[cur_q.usage] && elapsed < TimeBits'(window_i))) begin
                ovld_q  <= 1'b1;
                usage_o <= cur_q.usage;
                last_o  <= 1'b1;
                if (cur_q.press && cnt_q >= CntW'(MaxHeld)) begin
                  key_down_o    <= 1'b0;
                  report_kind_o <= RPT_FULL;
                end else begin
                  key_down_o    <= cur_q.press;
                  report_kind_o <= RPT_CHANGE;
                  seen_q[cur_q.usage] <= 1'b1;
                  if (cur_q.press) begin
                    held_q[cnt_q[IdxW-1:0]] <= cur_q.usage;
                    cnt_q <= cnt_q + 1'b1;
                  end else begin
                    idx_q   <= pos_q[IdxW-1:0];
                    state_q <= ST_SHIFT;
                  end
                end
              end
            end
          end
        end
        ST_SHIFT: begin
          // close the gap left by a release, one entry per cycle
          if (CntW'(idx_q) + 1'b1 < cnt_q) begin
            held_q[idx_q] <= held_q[idx_q + 1'b1];
            idx_q <= idx_q + 1'b1;
          end else begin
            cnt_q   <= cnt_q - 1'b1;
            state_q <= ST_IDLE;
          end
        end
        ST_WALK: begin
          if (!ovld_q) begin
            ovld_q        <= 1'b1;
            usage_o       <= held_q[idx_q];
            key_down_o    <= !walk_rel_q;
            report_kind_o <= walk_rel_q ? RPT_RELEASE : RPT_KEEP;
            last_o        <= CntW'(idx_q) + 1'b1 == cnt_q;
            if (CntW'(idx_q) + 1'b1 == cnt_q) begin
              state_q <= ST_IDLE;
              if (walk_rel_q) cnt_q <= '0;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        ST_CLEAR: state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/scancode_to_hid_key_state_tracker.sv
// top level of the scan code to hid key state tracker
// depends on sckt_pkg, sckt_front, sckt_fifo, sckt_back
//
// channel   dir  handshake             payload
// s_axis    in   s_axis_tvalid/tready  tuser: kind; tdata: scan_code, extended, key_break,
//                                      vkey_invalid
// m_axis    out  m_axis_tvalid/tready  tuser: report_kind; tdata: usage_code, key_down;
//                                      tlast: last
// cfg       in   cfg_we_i              cfg_idx_i selects register, cfg_data_i value
//
// front takes one word per cycle while the four deep queue has room
// a key event in the back end scans any held entries, looks up the debounce time and decides;
//   a release then shifts the later held entries down to close the gap
// keepalive and disable walk the held list one word at a time, since the walk waits for each
//   word to leave the output register before loading the next
// a stalled master side holds the back end; the queue absorbs the front
// reset clears enable, time, held count and the debounce seen bits at once
module scancode_to_hid_key_state_tracker
  import sckt_pkg::*;
#(
  parameter int unsigned MAX_HELD  = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // scan_code[7:0], extended[8], key_break[9], vkey_invalid[10]
  input  logic [2:0]  s_axis_tuser,  // kind[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // usage_code[7:0], key_down[8]
  output logic [1:0]  m_axis_tuser,  // report_kind[1:0]
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  logic [255:0] allowed_q;
  logic         filter_q;
  logic [7:0]   window_q;
  logic         push, full, fvalid, pop;
  cmd_t         cmd_in, cmd_out;
  logic [7:0]   usage;
  logic         down, lst;
  logic [1:0]   rk;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allowed_q <= '0;
      filter_q  <= 1'b0;
      window_q  <= 8'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MASK0:  allowed_q[63:0]    <= cfg_data_i;
        REG_MASK1:  allowed_q[127:64]  <= cfg_data_i;
        REG_MASK2:  allowed_q[191:128] <= cfg_data_i;
        REG_MASK3:  allowed_q[255:192] <= cfg_data_i;
        REG_FILTER: filter_q <= cfg_data_i[0];
        REG_WINDOW: window_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  sckt_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .kind_i         (s_axis_tuser),
    .scan_code_i    (s_axis_tdata[7:0]),
    .extended_i     (s_axis_tdata[8]),
    .key_break_i    (s_axis_tdata[9]),
    .vkey_invalid_i (s_axis_tdata[10]),
    .allowed_i      (allowed_q),
    .filter_en_i    (filter_q),
    .push_o         (push),
    .cmd_o          (cmd_in),
    .full_i         (full)
  );

  sckt_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (fvalid),
    .data_o  (cmd_out)
  );

  sckt_back #(.MaxHeld(MAX_HELD), .TimeBits(TIME_BITS)) u_back (
    .clk_i, .rst_ni,
    .valid_i       (fvalid),
    .cmd_i         (cmd_out),
    .pop_o         (pop),
    .window_i      (window_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .usage_o       (usage),
    .key_down_o    (down),
    .report_kind_o (rk),
    .last_o        (lst)
  );

  assign m_axis_tdata = {7'd0, down, usage};
  assign m_axis_tuser = rk;
  assign m_axis_tlast = lst;

endmodule

// File: rtl/sckt_checker.sv
// port-level checks for the tracker
// depends on sckt_pkg and the top level ports only, bound below
module sckt_checker
  import sckt_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:9] == 7'd0)
    else $error("pad bits set");

  a_full_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == RPT_FULL |-> m_axis_tlast && !m_axis_tdata[8])
    else $error("full report malformed");

  a_rel_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == RPT_RELEASE |-> !m_axis_tdata[8])
    else $error("release report shows key down");

endmodule

bind scancode_to_hid_key_state_tracker sckt_checker u_sckt_checker (.*);

// File: test/scancode_to_hid_key_state_tracker_tb.sv
// testbench for scancode_to_hid_key_state_tracker: directed table, held-list fill, random keys
// results are checked against typed rows or an in-bench key-state predictor with own scan maps
// depends on sckt_pkg and the rtl top level
module scancode_to_hid_key_state_tracker_tb
  import sckt_pkg::*;
;

  localparam int HeldMax   = 16;
  localparam int DrainWait = 256;  // queued words still working through the back end

  // directed row codes for the typed expectation
  localparam int ExpPredict = -1;
  localparam int ExpNone    = 0;
  localparam int ExpOne     = 1;

  // scan code to usage pairs {scan, usage}, own copy of the keyboard maps
  localparam int PlainN = 85;
  localparam int ExtN   = 18;
  localparam logic [PlainN*16-1:0] PLAIN_PAIRS = {
    16'h0129, 16'h3B3A, 16'h3C3B, 16'h3D3C, 16'h3E3D, 16'h3F3E, 16'h403F, 16'h4140,
    16'h4241, 16'h4342, 16'h4443, 16'h5744, 16'h5845, 16'h2935, 16'h021E, 16'h031F,
    16'h0420, 16'h0521, 16'h0622, 16'h0723, 16'h0824, 16'h0925, 16'h0A26, 16'h0B27,
    16'h0C2D, 16'h0D2E, 16'h0E2A, 16'h0F2B, 16'h1014, 16'h111A, 16'h1208, 16'h1315,
    16'h1417, 16'h151C, 16'h1618, 16'h170C, 16'h1812, 16'h1913, 16'h1A2F, 16'h1B30,
    16'h2B31, 16'h3A39, 16'h1E04, 16'h1F16, 16'h2007, 16'h2109, 16'h220A, 16'h230B,
    16'h240D, 16'h250E, 16'h260F, 16'h2733, 16'h2834, 16'h1C28, 16'h2AE1, 16'h2C1D,
    16'h2D1B, 16'h2E06, 16'h2F19, 16'h3005, 16'h3111, 16'h3210, 16'h3336, 16'h3437,
    16'h3538, 16'h36E5, 16'h1DE0, 16'h38E2, 16'h392C, 16'h4647, 16'h4553, 16'h3755,
    16'h4A56, 16'h4E57, 16'h4F59, 16'h505A, 16'h515B, 16'h4B5C, 16'h4C5D, 16'h4D5E,
    16'h475F, 16'h4860, 16'h4961, 16'h5262, 16'h5363};
  localparam logic [ExtN*16-1:0] EXT_PAIRS = {
    16'h1DE4, 16'h38E6, 16'h5BE3, 16'h5CE7, 16'h5D65, 16'h5249, 16'h474A, 16'h494B,
    16'h534C, 16'h4F4D, 16'h514E, 16'h4852, 16'h4B50, 16'h5051, 16'h4D4F, 16'h1C58,
    16'h3554, 16'h3746};

  typedef struct packed {
    logic [7:0] usage;
    logic       down;
    rpt_kind_e  kind;
    logic       last;
  } report_t;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] sc;
    logic       ext;
    logic       brk;
    logic       inv;
    int         typed;
    logic [7:0] usage;
    logic       down;
    rpt_kind_e  rk;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // scan_code[7:0], extended[8], key_break[9], vkey_invalid[10]
  logic [2:0]  s_axis_tuser = '0;  // kind[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;  // usage_code[7:0], key_down[8]
  logic [1:0]  m_axis_tuser;  // report_kind[1:0]
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;

  scancode_to_hid_key_state_tracker dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #6 clk_i = ~clk_i;

  // predictor state and config copy
  logic [7:0]  plain_map [256];
  logic [7:0]  ext_map [256];
  logic [63:0] mask_q [4];
  logic        filter_on;
  logic [7:0]  window_ms;
  logic        tracking_on;
  logic [31:0] now_ms;
  logic [7:0]  held_keys [HeldMax];
  int          held_n;
  logic        touched [256];
  logic [31:0] touch_ms [256];

  report_t reports_due [$];   // expected results in order
  report_t step_reports [$];  // results of the word just accepted

  int  mismatches = 0;
  int  words_sent = 0;
  int  reports_seen = 0;
  bit  no_idle = 1'b0;
  row_t rows [$];

  // master side stall pattern
  always @(negedge clk_i) begin
    m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 30);
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      report_t got, want;
      got.usage = m_axis_tdata[7:0];
      got.down  = m_axis_tdata[8];
      got.kind  = rpt_kind_e'(m_axis_tuser);
      got.last  = m_axis_tlast;
      reports_seen++;
      if (reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word usage=%h down=%b kind=%0d last=%b",
                                       got.usage, got.down, got.kind, got.last);
      end else begin
        want = reports_due.pop_front();
        if (got.usage !== want.usage || got.down !== want.down ||
            got.kind !== want.kind || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp usage=%h down=%b kind=%0d last=%b got %h %b %0d %b",
                     want.usage, want.down, want.kind, want.last,
                     got.usage, got.down, got.kind, got.last);
        end
      end
    end
  end

  function automatic void add_report(logic [7:0] u, logic d, rpt_kind_e k);
    report_t r;
    r.usage = u; r.down = d; r.kind = k; r.last = 1'b0;
    step_reports.push_back(r);
  endfunction

  // turn tracking off, release every held key in press order and forget the debounce history
  function automatic void release_all();
    tracking_on = 1'b0;
    for (int i = 0; i < held_n; i++) add_report(held_keys[i], 1'b0, RPT_RELEASE);
    held_n = 0;
    foreach (touched[i]) touched[i] = 1'b0;
  endfunction

  function automatic void track_key(logic [7:0] sc, logic ext, logic brk, logic inv);
    logic [7:0] u;
    int pos;
    pos = -1;
    if (!tracking_on || inv || sc == 8'h00) return;
    u = ext ? ext_map[sc] : plain_map[sc];
    if (u == 8'h00) return;
    if (u == UsageEnd) begin
      // end press shuts the block off, end release is ignored
      if (!brk) release_all();
      return;
    end
    if (filter_on && !mask_q[u[7:6]][u[5:0]]) return;
    for (int i = 0; i < held_n; i++) if (held_keys[i] == u && pos < 0) pos = i;
    if (!brk == (pos >= 0)) return;  // no state change
    if (touched[u] && (now_ms - touch_ms[u]) < {24'd0, window_ms}) return;  // bounce
    if (!brk) begin
      if (held_n >= HeldMax) begin
        add_report(u, 1'b0, RPT_FULL);
        return;
      end
      held_keys[held_n++] = u;
    end else begin
      for (int i = pos; i + 1 < held_n; i++) held_keys[i] = held_keys[i + 1];
      held_n--;
    end
    touched[u] = 1'b1;
    touch_ms[u] = now_ms;
    add_report(u, !brk, RPT_CHANGE);
  endfunction

  function automatic void predict_word(logic [2:0] k, logic [7:0] sc, logic ext,
                                       logic brk, logic inv);
    step_reports.delete();
    case (k)
      KIND_KEY:     track_key(sc, ext, brk, inv);
      KIND_TICK:    now_ms = now_ms + 32'd1;
      KIND_KEEP: begin
        if (tracking_on)
          for (int i = 0; i < held_n; i++) add_report(held_keys[i], 1'b1, RPT_KEEP);
      end
      KIND_ENABLE:  tracking_on = 1'b1;
      KIND_DISABLE: release_all();
      default: ;
    endcase
    if (step_reports.size() > 0) step_reports[step_reports.size() - 1].last = 1'b1;
  endfunction

  // hand one word to the block, with random gaps before it unless no_idle is set
  task automatic send_word(logic [2:0] k, logic [7:0] sc, logic ext, logic brk, logic inv);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(0, 99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= {5'b00000, inv, brk, ext, sc};
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  task automatic push_word(logic [2:0] k, logic [7:0] sc, logic ext, logic brk, logic inv);
    send_word(k, sc, ext, brk, inv);
    predict_word(k, sc, ext, brk, inv);
    foreach (step_reports[i]) reports_due.push_back(step_reports[i]);
  endtask

  // wait until every result is out and the back end has gone quiet
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MASK0:  mask_q[0] = val;
      REG_MASK1:  mask_q[1] = val;
      REG_MASK2:  mask_q[2] = val;
      REG_MASK3:  mask_q[3] = val;
      REG_FILTER: filter_on = val[0];
      REG_WINDOW: window_ms = val[7:0];
      default: ;
    endcase
  endtask

  function automatic row_t mk_row(logic [2:0] k, logic [7:0] sc, logic ext, logic brk,
                                  logic inv, int typed, logic [7:0] u, logic d,
                                  rpt_kind_e rk);
    row_t r;
    r.kind = k; r.sc = sc; r.ext = ext; r.brk = brk; r.inv = inv;
    r.typed = typed; r.usage = u; r.down = d; r.rk = rk;
    return r;
  endfunction

  // one random word; most are presses and releases of a small key pool
  task automatic random_word();
    int r, p;
    logic [7:0] sc;
    logic ext;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      p = $urandom_range(0, 19);
      if (p < 14) begin
        sc = PLAIN_PAIRS[(PlainN - 1 - p) * 16 + 8 +: 8]; ext = 1'b0;
      end else begin
        sc = EXT_PAIRS[(ExtN - 1 - (p - 14)) * 16 + 8 +: 8]; ext = 1'b1;
      end
      push_word(KIND_KEY, sc, ext, 1'($urandom_range(0, 1)), $urandom_range(0, 99) < 5);
    end else if (r < 65)
      push_word(KIND_KEY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    else if (r < 85) push_word(KIND_TICK, 8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
    else if (r < 91) push_word(KIND_KEEP, 8'h00, 1'b0, 1'b0, 1'b0);
    else if (r < 95) push_word(KIND_ENABLE, 8'h00, 1'b0, 1'b0, 1'b0);
    else if (r < 97) push_word(KIND_DISABLE, 8'h00, 1'b0, 1'b0, 1'b0);
    else if (r < 98)
      push_word(KIND_KEY, 8'h4F, 1'b1, 1'($urandom_range(0, 1)), 1'b0);  // end key
    else push_word(3'($urandom_range(5, 7)), 8'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b1);
  endtask

  initial begin
    report_t t;
    logic [15:0] pr;
    foreach (plain_map[i]) begin
      plain_map[i] = 8'h00; ext_map[i] = 8'h00; touched[i] = 1'b0; touch_ms[i] = '0;
    end
    for (int i = 0; i < PlainN; i++) begin
      pr = PLAIN_PAIRS[i * 16 +: 16];
      plain_map[pr[15:8]] = pr[7:0];
    end
    for (int i = 0; i < ExtN; i++) begin
      pr = EXT_PAIRS[i * 16 +: 16];
      ext_map[pr[15:8]] = pr[7:0];
    end
    foreach (mask_q[i]) mask_q[i] = '0;
    filter_on = 1'b0; window_ms = 8'd3;
    tracking_on = 1'b0; now_ms = '0; held_n = 0;
    foreach (held_keys[i]) held_keys[i] = '0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part at reset settings, window 3 ms
    rows.push_back(mk_row(KIND_KEY, 8'h1E, 1'b0, 1'b0, 1'b0, ExpNone, 8'h00, 1'b0,
                          RPT_CHANGE));  // disabled
    rows.push_back(mk_row(KIND_KEEP, 8'h00, 1'b0, 1'b0, 1'b0, ExpNone, 8'h00, 1'b0,
                          RPT_CHANGE));
    rows.push_back(mk_row(KIND_ENABLE, 8'h00, 1'b0, 1'b0, 1'b0, ExpNone, 8'h00, 1'b0,
                          RPT_CHANGE));
    rows.push_back(mk_row(KIND_KEY, 8'h01, 1'b0, 1'b0, 1'b0, ExpOne, 8'h29, 1'b1,
                          RPT_CHANGE));
    rows.push_back(mk_row(KIND_KEY, 8'h1D, 1'b1, 1'b0, 1'b0, ExpOne, 8'hE4, 1'b1,
                          RPT_CHANGE));
    rows.push_back(mk_row(KIND_KEY, 8'h1E, 1'b0, 1'b0, 1'b1, ExpNone, 8'h00, 1'b0,
                          RPT_CHANGE));  // fake key
    rows.push_back(mk_row(KIND_KEY, 8'h00, 1'b0, 1'b0, 1'b0, ExpNone, 8'h00, 1'b0,
                          RPT_CHANGE));  // scan zero
    rows.push_back(mk_row(KIND_KEY, 8'hFF, 1'b1, 1'b1, 1'b0, ExpNone, 8'h00, 1'b0,
                          RPT_CHANGE));  // unmapped
    rows.push_back(mk_row(KIND_KEY, 8'hFF, 1'b0, 1'b0, 1'b0, ExpNone, 8'h00, 1'b0,
                          RPT_CHANGE));
    rows.push_back(mk_row(KIND_KEY, 8'h1D, 1'b1, 1'b0, 1'b0, ExpNone, 8'h00, 1'b0,
                          RPT_CHANGE));  // repeat
    rows.push_back(mk_row(KIND_KEY, 8'h1D, 1'b1, 1'b1, 1'b0, ExpNone, 8'h00, 1'b0,
                          RPT_CHANGE));  // bounce
    rows.push_back(mk_row(KIND_TICK, 8'h00, 1'b0, 1'b0, 1'b0, ExpNone, 8'h00, 1'b0,
                          RPT_CHANGE));
    rows.push_back(mk_row(KIND_TICK, 8'hFF, 1'b1, 1'b1, 1'b1, ExpNone, 8'h00, 1'b0,
                          RPT_CHANGE));
    rows.push_back(mk_row(KIND_TICK, 8'h00, 1'b0, 1'b0, 1'b0, ExpNone, 8'h00, 1'b0,
                          RPT_CHANGE));
    rows.push_back(mk_row(KIND_KEY, 8'h1D, 1'b1, 1'b1, 1'b0, ExpOne, 8'hE4, 1'b0,
                          RPT_CHANGE));
    rows.push_back(mk_row(KIND_KEEP, 8'h00, 1'b0, 1'b0, 1'b0, ExpOne, 8'h29, 1'b1,
                          RPT_KEEP));
    rows.push_back(mk_row(KIND_KEY, 8'h4F, 1'b1, 1'b1, 1'b0, ExpNone, 8'h00, 1'b0,
                          RPT_CHANGE));  // end release
    rows.push_back(mk_row(3'd5, 8'h01, 1'b0, 1'b0, 1'b0, ExpNone, 8'h00, 1'b0,
                          RPT_CHANGE));  // unused kinds
    rows.push_back(mk_row(3'd7, 8'h01, 1'b1, 1'b1, 1'b1, ExpNone, 8'h00, 1'b0,
                          RPT_CHANGE));
    rows.push_back(mk_row(KIND_KEY, 8'h53, 1'b0, 1'b0, 1'b0, ExpPredict, 8'h00, 1'b0,
                          RPT_CHANGE));
    rows.push_back(mk_row(KIND_KEY, 8'h4F, 1'b1, 1'b0, 1'b0, ExpPredict, 8'h00, 1'b0,
                          RPT_CHANGE));  // end press
    rows.push_back(mk_row(KIND_KEEP, 8'h00, 1'b0, 1'b0, 1'b0, ExpNone, 8'h00, 1'b0,
                          RPT_CHANGE));
    rows.push_back(mk_row(KIND_DISABLE, 8'h00, 1'b0, 1'b0, 1'b0, ExpNone, 8'h00, 1'b0,
                          RPT_CHANGE));
    foreach (rows[i]) begin
      send_word(rows[i].kind, rows[i].sc, rows[i].ext, rows[i].brk, rows[i].inv);
      predict_word(rows[i].kind, rows[i].sc, rows[i].ext, rows[i].brk, rows[i].inv);
      if (rows[i].typed == ExpPredict)
        foreach (step_reports[j]) reports_due.push_back(step_reports[j]);
      else if (rows[i].typed == ExpOne) begin
        t.usage = rows[i].usage; t.down = rows[i].down; t.kind = rows[i].rk; t.last = 1'b1;
        reports_due.push_back(t);
      end
    end
    drain();

    // fill the held list past its end with no debounce, then walk it twice
    write_reg(REG_WINDOW, 64'd0);
    push_word(KIND_ENABLE, 8'h00, 1'b0, 1'b0, 1'b0);
    for (int i = 0; i < HeldMax + 1; i++)
      push_word(KIND_KEY, PLAIN_PAIRS[(PlainN - 1 - i) * 16 + 8 +: 8], 1'b0, 1'b0, 1'b0);
    push_word(KIND_KEEP, 8'h00, 1'b0, 1'b0, 1'b0);
    push_word(KIND_KEY, 8'h01, 1'b0, 1'b1, 1'b0);  // release the oldest to close a gap
    push_word(KIND_DISABLE, 8'h00, 1'b0, 1'b0, 1'b0);
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_FILTER, 64'd0);
          write_reg(REG_WINDOW, 64'd0);
        end
        1: begin
          for (int m = 0; m < 4; m++)
            write_reg(REG_MASK0 + 3'(m), {$urandom, $urandom} | {$urandom, $urandom});
          write_reg(REG_FILTER, 64'd1);
          write_reg(REG_WINDOW, 64'd1);
        end
        2: begin
          // long stretch with no inserted input gaps and no master side stalls
          no_idle = 1'b1;
          for (int m = 0; m < 4; m++) write_reg(REG_MASK0 + 3'(m), '1);
          write_reg(REG_WINDOW, 64'd255);
        end
        default: begin
          no_idle = 1'b0;
          write_reg(REG_MASK1, '0);
          write_reg(REG_MASK3, {$urandom, $urandom});
          write_reg(REG_WINDOW, 64'($urandom_range(1, 6)));
        end
      endcase
      push_word(KIND_ENABLE, 8'h00, 1'b0, 1'b0, 1'b0);
      repeat (94) random_word();
      drain();
    end

    $display("sent %0d words, checked %0d results over reset, no-debounce, filtered",
             words_sent, reports_seen);
    $display("and long-debounce settings, %0d mismatches", mismatches);
    if (mismatches == 0) $display("scancode_to_hid_key_state_tracker_tb passed");
    else $display("scancode_to_hid_key_state_tracker_tb failed");
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #3000000;
    $display("scancode_to_hid_key_state_tracker_tb failed");
    $finish;
  end

endmodule

// File: files.f
rtl/sckt_pkg.sv
rtl/sckt_front.sv
rtl/sckt_fifo.sv
rtl/sckt_back.sv
rtl/scancode_to_hid_key_state_tracker.sv
rtl/sckt_checker.sv
test/scancode_to_hid_key_state_tracker_tb.sv
